// File: src/rmsn_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the RMS row normalizer.
// No dependencies; imported by every module of the block.
package rmsn_pkg;

  localparam int MaxRow = 64;
  localparam int RowIdxW = (MaxRow > 1) ? $clog2(MaxRow) : 1;

  localparam logic [31:0] OneBits  = 32'h3F80_0000;
  localparam logic [31:0] ZeroBits = 32'h0000_0000;
  localparam logic [31:0] QnanBits = 32'h7FC0_0000;
  localparam logic [31:0] InfBits  = 32'h7F80_0000;

  localparam logic [6:0]  RowLengthReset = 7'd64;
  localparam logic [31:0] EpsReset       = 32'h3727_C5AC;

  typedef enum logic {
    REG_ROW_LENGTH = 1'b0,
    REG_EPS        = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_ADD,
    OP_DIV,
    OP_SQRT
  } fpu_op_t;

  typedef struct packed {
    logic        start;
    fpu_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        idle;
    logic        done;
    logic [31:0] result;
  } fpu_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_MEAN,
    ST_EPS,
    ST_ROOT,
    ST_SCALE,
    ST_FETCH,
    ST_OUTMUL,
    ST_EMIT
  } step_t;

  typedef enum logic [2:0] {
    EN_IDLE,
    EN_DIV,
    EN_SQNORM,
    EN_SQRT,
    EN_NORM,
    EN_ROUND,
    EN_DONE
  } eng_t;

endpackage

// File: src/rms_row_normalizer.sv
`timescale 1ns / 1ps
// RMS normalizer for rows of float32 samples: top level with row store and sequencer.
// Depends on rmsn_pkg and rmsn_fpu.

// Samples are taken one per request and stored; each costs a square and an add on
// the single shared float unit, and the square takes longer when it needs a long
// normalizing shift for subnormal values. On the row's last sample the block
// forms sum/n, adds epsilon, takes the root and its reciprocal: two 49-step
// divides, a 25-step square root and their normalize and round steps. Then each
// stored sample is multiplied by the scale and sent. No sample is taken while a
// row is being computed or drained.
module rms_row_normalizer (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  rmsn_pkg::cfg_reg_t  cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                sample_valid,
  output logic                sample_ready,
  input  logic [31:0]         sample,
  output logic                result_valid,
  input  logic                result_ready,
  output logic [31:0]         normalized,
  output logic                row_end
);
  import rmsn_pkg::*;

  function automatic logic [31:0] count_to_float(input logic [6:0] c);
    logic [2:0]  msb;
    logic [23:0] sh;
    msb = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (c[i]) msb = 3'(i);
    end
    sh = 24'(c) << (5'd23 - 5'(msb));
    return {1'b0, 8'(8'd127 + 8'(msb)), sh[22:0]};
  endfunction

  step_t               step;
  step_t               step_next;
  fpu_req_t            req;
  fpu_rsp_t            rsp;

  logic [6:0]          row_length;
  logic [31:0]         eps_bits;
  logic [31:0]         square_sum;
  logic [6:0]          fill_count;
  logic [6:0]          n;
  logic [RowIdxW-1:0]  k;
  logic [31:0]         cur;
  logic [31:0]         scale;
  logic [31:0]         rd;
  logic [31:0]         row_store [MaxRow];

  logic [6:0]          len_eff;
  logic                accept;
  logic                slot;
  logic                last;

  assign len_eff = (row_length == 7'd0) ? 7'd1 :
                   (row_length > 7'(MaxRow)) ? 7'(MaxRow) : row_length;
  assign accept  = sample_valid && sample_ready;
  assign slot    = !result_valid || result_ready;
  assign last    = ((7'(k) + 7'd1) == n);

  rmsn_fpu u_fpu (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_comb begin
    step_next = step;
    unique case (step)
      ST_IDLE:   if (sample_valid) step_next = ST_SQUARE;
      ST_SQUARE: if (rsp.done) step_next = ST_ACCUM;
      ST_ACCUM:  if (rsp.done) step_next = (n < len_eff) ? ST_IDLE : ST_MEAN;
      ST_MEAN:   if (rsp.done) step_next = ST_EPS;
      ST_EPS:    if (rsp.done) step_next = ST_ROOT;
      ST_ROOT:   if (rsp.done) step_next = ST_SCALE;
      ST_SCALE:  if (rsp.done) step_next = ST_FETCH;
      ST_FETCH:  step_next = ST_OUTMUL;
      ST_OUTMUL: if (rsp.done) step_next = ST_EMIT;
      ST_EMIT:   if (slot) step_next = last ? ST_IDLE : ST_FETCH;
      default:   step_next = ST_IDLE;
    endcase
  end

  always_comb begin
    sample_ready = (step == ST_IDLE);
    req.start    = 1'b0;
    req.op       = OP_MUL;
    req.a        = cur;
    req.b        = cur;
    unique case (step)
      ST_SQUARE: begin
        req.start = rsp.idle;
      end
      ST_ACCUM: begin
        req.start = rsp.idle;
        req.op    = OP_ADD;
        req.a     = square_sum;
      end
      ST_MEAN: begin
        req.start = rsp.idle;
        req.op    = OP_DIV;
        req.a     = square_sum;
        req.b     = count_to_float(n);
      end
      ST_EPS: begin
        req.start = rsp.idle;
        req.op    = OP_ADD;
        req.b     = eps_bits;
      end
      ST_ROOT: begin
        req.start = rsp.idle;
        req.op    = OP_SQRT;
      end
      ST_SCALE: begin
        req.start = rsp.idle;
        req.op    = OP_DIV;
        req.a     = OneBits;
      end
      ST_OUTMUL: begin
        req.start = rsp.idle;
        req.a     = rd;
        req.b     = scale;
      end
      default: req.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= ST_IDLE;
      row_length   <= RowLengthReset;
      eps_bits     <= EpsReset;
      square_sum   <= ZeroBits;
      fill_count   <= 7'd0;
      result_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_ROW_LENGTH: row_length <= cfg_data[6:0];
          REG_EPS:        eps_bits   <= cfg_data;
          default:        ;
        endcase
      end
      if (step == ST_ACCUM && rsp.done) begin
        square_sum <= rsp.result;
        if (n < len_eff) fill_count <= n;
      end
      if (step == ST_EMIT && slot) begin
        result_valid <= 1'b1;
        if (last) begin
          fill_count <= 7'd0;
          square_sum <= ZeroBits;
        end
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= sample;
      n   <= fill_count + 7'd1;
    end
    if (rsp.done && (step == ST_SQUARE || step == ST_MEAN || step == ST_EPS ||
                     step == ST_ROOT || step == ST_OUTMUL)) begin
      cur <= rsp.result;
    end
    if (step == ST_SCALE && rsp.done) begin
      scale <= rsp.result;
      k     <= '0;
    end
    if (step == ST_EMIT && slot) begin
      normalized <= cur;
      row_end    <= last;
      if (!last) k <= k + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row_store[fill_count[RowIdxW-1:0]] <= sample;
    end
    rd <= row_store[k];
  end

endmodule

// File: src/rmsn_fpu.sv
`timescale 1ns / 1ps
// Shared float32 unit: multiply, add, bit-serial divide and square root,
// one normalizer and one round-to-nearest-even packer. Depends on rmsn_pkg.
module rmsn_fpu (
  input  logic               clk,
  input  logic               rst,
  input  rmsn_pkg::fpu_req_t req,
  output rmsn_pkg::fpu_rsp_t rsp
);
  import rmsn_pkg::*;

  typedef struct packed {
    logic        sign;
    logic [7:0]  e;
    logic [23:0] m;
    logic        zero;
    logic        inf;
    logic        nan;
  } unp_t;

  function automatic unp_t unpack(input logic [31:0] x);
    unp_t u;
    u.sign = x[31];
    u.e    = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    u.m    = {(x[30:23] != 8'd0), x[22:0]};
    u.zero = (x[30:0] == 31'd0);
    u.inf  = (x[30:0] == InfBits[30:0]);
    u.nan  = (x[30:0] > InfBits[30:0]);
    return u;
  endfunction

  // value = sg / 2^49 * 2^(ex - 127)
  function automatic logic [31:0] round_pack(input logic sign, input logic signed [10:0] ex,
                                             input logic [49:0] sg);
    logic [25:0] ext;
    logic [25:0] sh;
    logic [25:0] mask;
    logic [10:0] amt;
    logic [4:0]  s;
    logic signed [10:0] e1;
    logic signed [10:0] e2;
    logic [24:0] m;
    logic [23:0] mf;
    logic        inc;
    ext = {sg[49:25], |sg[24:0]};
    e1  = ex;
    if (ex < 11'sd1) begin
      amt  = 11'(11'sd1 - ex);
      s    = (amt > 11'd26) ? 5'd26 : amt[4:0];
      sh   = ext >> s;
      mask = (26'd1 << s) - 26'd1;
      ext  = {sh[25:1], sh[0] | (|(ext & mask))};
      e1   = 11'sd1;
    end
    inc = ext[1] & (ext[0] | ext[2]);
    m   = {1'b0, ext[25:2]} + {24'd0, inc};
    if (m[24]) begin
      mf = m[24:1];
      e2 = e1 + 11'sd1;
    end else begin
      mf = m[23:0];
      e2 = e1;
    end
    if (e2 >= 11'sd255) begin
      return {sign, InfBits[30:0]};
    end
    return {sign, (mf[23] ? e2[7:0] : 8'd0), mf[22:0]};
  endfunction

  eng_t               state;
  eng_t               state_next;
  logic               sign;
  logic signed [10:0] exp;
  logic [49:0]        sig;
  logic [24:0]        rem;
  logic [23:0]        dvs;
  logic [5:0]         cnt;
  logic [49:0]        sv;
  logic [49:0]        sres;
  logic [49:0]        sbit;
  logic [31:0]        rbits;

  unp_t               ua;
  unp_t               ub;
  unp_t               big;
  unp_t               sml;
  logic               sx;
  logic               ld_special;
  logic [31:0]        ld_bits;
  logic               ld_sign;
  logic [49:0]        ld_sig;
  logic signed [10:0] ld_exp;
  eng_t               ld_state;
  logic [47:0]        prod;
  logic [7:0]         d;
  logic [49:0]        bigx;
  logic [49:0]        smx;
  logic [49:0]        sma;
  logic [49:0]        smsh;
  logic [49:0]        add_sum;

  logic               dv_ge;
  logic [24:0]        dv_diff;
  logic [49:0]        sq_t;
  logic               sq_ge;
  logic [49:0]        sq_v_n;
  logic [49:0]        sq_res_n;
  logic signed [10:0] sq_tmp;

  always_comb begin
    ua         = unpack(req.a);
    ub         = unpack(req.b);
    sx         = ua.sign ^ ub.sign;
    ld_special = 1'b0;
    ld_bits    = ZeroBits;
    ld_sign    = sx;
    ld_sig     = '0;
    ld_exp     = '0;
    ld_state   = EN_NORM;
    prod       = ua.m * ub.m;
    big        = (req.a[30:0] >= req.b[30:0]) ? ua : ub;
    sml        = (req.a[30:0] >= req.b[30:0]) ? ub : ua;
    d          = big.e - sml.e;
    bigx       = {1'b0, big.m, 25'd0};
    smx        = {1'b0, sml.m, 25'd0};
    smsh       = smx >> d;
    if (d >= 8'd50) begin
      sma = {49'd0, |smx};
    end else begin
      sma = {smsh[49:1], smsh[0] | (|(smx & ~({50{1'b1}} << d)))};
    end
    add_sum = (big.sign == sml.sign) ? (bigx + sma) : (bigx - sma);
    case (req.op)
      OP_MUL: begin
        if (ua.nan || ub.nan || (ua.inf && ub.zero) || (ua.zero && ub.inf)) begin
          ld_special = 1'b1;
          ld_bits    = QnanBits;
        end else if (ua.inf || ub.inf) begin
          ld_special = 1'b1;
          ld_bits    = {sx, InfBits[30:0]};
        end else if (ua.zero || ub.zero) begin
          ld_special = 1'b1;
          ld_bits    = {sx, 31'd0};
        end
        ld_sig = {prod, 2'b00};
        ld_exp = $signed(11'({3'd0, ua.e}) + 11'({3'd0, ub.e}) - 11'd126);
      end
      OP_ADD: begin
        if (ua.nan || ub.nan || (ua.inf && ub.inf && sx)) begin
          ld_special = 1'b1;
          ld_bits    = QnanBits;
        end else if (ua.inf) begin
          ld_special = 1'b1;
          ld_bits    = req.a;
        end else if (ub.inf) begin
          ld_special = 1'b1;
          ld_bits    = req.b;
        end else if (ua.zero && ub.zero) begin
          ld_special = 1'b1;
          ld_bits    = {ua.sign & ub.sign, 31'd0};
        end else if (add_sum == 50'd0) begin
          ld_special = 1'b1;
          ld_bits    = ZeroBits;
        end
        ld_sign = big.sign;
        ld_sig  = add_sum;
        ld_exp  = $signed(11'({3'd0, big.e}) + 11'd1);
      end
      OP_DIV: begin
        if (ua.nan || ub.nan || (ua.zero && ub.zero) || (ua.inf && ub.inf)) begin
          ld_special = 1'b1;
          ld_bits    = QnanBits;
        end else if (ua.inf || ub.zero) begin
          ld_special = 1'b1;
          ld_bits    = {sx, InfBits[30:0]};
        end else if (ua.zero || ub.inf) begin
          ld_special = 1'b1;
          ld_bits    = {sx, 31'd0};
        end
        ld_exp   = $signed(11'({3'd0, ua.e}) - 11'({3'd0, ub.e}) + 11'd127);
        ld_state = EN_DIV;
      end
      OP_SQRT: begin
        if (ua.nan) begin
          ld_special = 1'b1;
          ld_bits    = QnanBits;
        end else if (ua.zero) begin
          ld_special = 1'b1;
          ld_bits    = req.a;
        end else if (ua.sign) begin
          ld_special = 1'b1;
          ld_bits    = QnanBits;
        end else if (ua.inf) begin
          ld_special = 1'b1;
          ld_bits    = InfBits;
        end
        ld_sign  = 1'b0;
        ld_sig   = {ua.m, 26'd0};
        ld_exp   = $signed({3'd0, ua.e});
        ld_state = EN_SQNORM;
      end
      default: ld_special = 1'b1;
    endcase
  end

  always_comb begin
    dv_ge    = (rem >= {1'b0, dvs});
    dv_diff  = dv_ge ? (rem - {1'b0, dvs}) : rem;
    sq_t     = sres + sbit;
    sq_ge    = (sv >= sq_t);
    sq_v_n   = sq_ge ? (sv - sq_t) : sv;
    sq_res_n = sq_ge ? ((sres >> 1) + sbit) : (sres >> 1);
    sq_tmp   = exp - 11'sd150 - (exp[0] ? 11'sd25 : 11'sd26);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      EN_IDLE:   if (req.start) state_next = ld_special ? EN_DONE : ld_state;
      EN_DIV:    if (cnt == 6'd0) state_next = EN_NORM;
      EN_SQNORM: if (sig[49]) state_next = EN_SQRT;
      EN_SQRT:   if (cnt == 6'd0) state_next = EN_ROUND;
      EN_NORM:   if (sig[49]) state_next = EN_ROUND;
      EN_ROUND:  state_next = EN_DONE;
      EN_DONE:   state_next = EN_IDLE;
      default:   state_next = EN_IDLE;
    endcase
  end

  always_comb begin
    rsp.idle   = (state == EN_IDLE);
    rsp.done   = (state == EN_DONE);
    rsp.result = rbits;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= EN_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      EN_IDLE: begin
        if (req.start) begin
          sign  <= ld_sign;
          exp   <= ld_exp;
          sig   <= (req.op == OP_DIV) ? 50'd0 : ld_sig;
          rem   <= {1'b0, ua.m};
          dvs   <= ub.m;
          cnt   <= 6'd48;
          rbits <= ld_bits;
        end
      end
      EN_DIV: begin
        if (cnt == 6'd0) begin
          sig <= {sig[47:0], dv_ge, |dv_diff};
        end else begin
          sig <= {sig[48:0], dv_ge};
        end
        rem <= {dv_diff[23:0], 1'b0};
        cnt <= cnt - 6'd1;
      end
      EN_SQNORM: begin
        if (sig[49]) begin
          sv   <= exp[0] ? {1'b0, sig[49:26], 25'd0} : {sig[49:26], 26'd0};
          sres <= '0;
          sbit <= 50'd1 << 48;
          cnt  <= 6'd24;
          exp  <= 11'sd151 + (sq_tmp >>> 1);
        end else begin
          sig <= {sig[48:0], 1'b0};
          exp <= exp - 11'sd1;
        end
      end
      EN_SQRT: begin
        sv   <= sq_v_n;
        sres <= sq_res_n;
        sbit <= sbit >> 2;
        cnt  <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          sig <= {sq_res_n[24:0], |sq_v_n, 24'd0};
        end
      end
      EN_NORM: begin
        if (!sig[49]) begin
          sig <= {sig[48:0], 1'b0};
          exp <= exp - 11'sd1;
        end
      end
      EN_ROUND: rbits <= round_pack(sign, exp, sig);
      default: ;
    endcase
  end

endmodule

// File: src/rmsn_checker.sv
`timescale 1ns / 1ps
// Port-level checks for rms_row_normalizer, attached by bind.
// Depends on rmsn_pkg.
module rmsn_checker (
  input logic        clk,
  input logic        rst,
  input logic        sample_valid,
  input logic        sample_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] normalized,
  input logic        row_end
);
  import rmsn_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("new request taken while previous one is in work");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(normalized) && $stable(row_end))
    else $error("stalled result changed");

  a_canonical_nan: assert property (@(posedge clk) disable iff (rst)
    result_valid && normalized[30:23] == 8'hFF && normalized[22:0] != 23'd0
      |-> normalized == QnanBits)
    else $error("non-canonical NaN on output");

endmodule

bind rms_row_normalizer rmsn_checker u_rmsn_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_ready (sample_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .normalized   (normalized),
  .row_end      (row_end)
);

// File: sim/rms_checker.sv
`timescale 1ns / 1ps
// Checker for the RMS row normalizer: watches the register port and the sample and
// result channels, predicts normalized rows in float32 and compares them. Depends on rmsn_pkg.
module rms_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  rmsn_pkg::cfg_reg_t  cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                sample_valid,
  input  logic                sample_ready,
  input  logic [31:0]         sample,
  input  logic                result_valid,
  input  logic                result_ready,
  input  logic [31:0]         normalized,
  input  logic                row_end,
  output int                  errors,
  output int                  pending
);
  import rmsn_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
  } norm_out_t;

  logic [31:0] row_buf [MaxRow];
  logic [31:0] sum_sq;
  int          held;
  logic [6:0]  len_reg;
  logic [31:0] eps_reg;
  norm_out_t   want_q [$];

  function automatic real f32_to_real(logic [31:0] b);
    real v;
    if (b[30:23] == 8'hFF) begin
      if (b[22:0] != 0) return $bitstoreal(64'h7FF8_0000_0000_0000);
      return $bitstoreal({b[31], 11'h7FF, 52'b0});
    end
    if (b[30:23] == 0) begin
      v = real'(b[22:0]) * $bitstoreal(64'h36A0_0000_0000_0000);
      return b[31] ? -v : v;
    end
    return $bitstoreal({b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'b0});
  endfunction

  // round a double to float32, nearest-even, subnormals kept
  function automatic logic [31:0] real_to_f32(real v);
    logic [63:0] d, m, q, rem, half, b;
    logic        sgn;
    int          e, sh;
    d = $realtobits(v);
    sgn = d[63];
    if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? QnanBits : {sgn, InfBits[30:0]};
    if (d[62:0] == 0) return {sgn, 31'b0};
    e = int'(d[62:52]) - 1023 + 127;
    m = {11'b0, 1'b1, d[51:0]};
    sh = (e >= 1) ? 29 : 29 + 1 - e;
    if (sh > 54) return {sgn, 31'b0};
    q = m >> sh;
    rem = m & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 1;
    b = (e >= 1) ? ((64'(e - 1) << 23) + q) : q;
    if (b >= 64'h7F80_0000) return {sgn, InfBits[30:0]};
    return {sgn, b[30:0]};
  endfunction

  function automatic logic is_nan(logic [31:0] b);
    return b[30:0] > InfBits[30:0];
  endfunction

  function automatic logic [31:0] root_f32(logic [31:0] a);
    if (is_nan(a)) return QnanBits;
    if (a[30:0] == 0) return a;
    if (a[31]) return QnanBits;
    return real_to_f32($sqrt(f32_to_real(a)));
  endfunction

  task automatic take_sample(logic [31:0] s);
    int          idx, len, n;
    logic [31:0] sq, mean, den, rt, scale, y;
    idx = (held >= MaxRow) ? MaxRow - 1 : held;
    len = int'(len_reg);
    if (len == 0) len = 1;
    if (len > MaxRow) len = MaxRow;
    row_buf[idx] = s;
    sq = real_to_f32(f32_to_real(s) * f32_to_real(s));
    sum_sq = real_to_f32(f32_to_real(sum_sq) + f32_to_real(sq));
    n = idx + 1;
    if (n < len) begin
      held = n;
      return;
    end
    mean = real_to_f32(f32_to_real(sum_sq) / real'(n));
    den = real_to_f32(f32_to_real(mean) + f32_to_real(eps_reg));
    rt = root_f32(den);
    if (rt[30:0] == 0) scale = {rt[31], InfBits[30:0]};
    else scale = real_to_f32(1.0 / f32_to_real(rt));
    for (int k = 0; k < n; k++) begin
      y = real_to_f32(f32_to_real(row_buf[k]) * f32_to_real(scale));
      if (is_nan(y)) y = QnanBits;
      want_q.push_back('{value: y, last: (k + 1 == n)});
    end
    held = 0;
    sum_sq = ZeroBits;
  endtask

  always @(posedge clk) begin
    norm_out_t w;
    if (rst) begin
      sum_sq = ZeroBits;
      held = 0;
      len_reg = RowLengthReset;
      eps_reg = EpsReset;
      errors = 0;
      want_q.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_ROW_LENGTH) len_reg = cfg_data[6:0];
        else eps_reg = cfg_data;
      end
      if (result_valid && result_ready) begin
        if (want_q.size() == 0) begin
          errors = errors + 1;
          $display("%0t: unexpected result %h row_end %b", $time, normalized, row_end);
        end else begin
          w = want_q.pop_front();
          if (w.value !== normalized || w.last !== row_end) begin
            errors = errors + 1;
            $display("%0t: expected %h row_end %b, actual %h row_end %b",
                     $time, w.value, w.last, normalized, row_end);
          end
        end
      end
      if (sample_valid && sample_ready) take_sample(sample);
    end
    pending = want_q.size();
  end
endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Testbench top for rms_row_normalizer: clock, reset, stimulus and verdict.
// Depends on rmsn_pkg, rms_row_normalizer and rms_checker.
module tb;
  import rmsn_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_write = 0;
  cfg_reg_t    cfg_index = REG_ROW_LENGTH;
  logic [31:0] cfg_data = 0;
  logic        sample_valid = 0;
  logic        sample_ready;
  logic [31:0] sample = 0;
  logic        result_valid;
  logic        result_ready = 0;
  logic [31:0] normalized;
  logic        row_end;
  int          errors, pending;
  int          cycles = 0;
  int          sent = 0;
  int          stall = 0;
  logic        steady = 0;

  localparam int Limit = 600000;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  rms_row_normalizer u_dut (.*);

  rms_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("tb: errors");
      $finish;
    end
  end

  function automatic int gap_len();
    if (steady) return 0;
    return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(8, 40);
  endfunction

  // stall the result side
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) steady <= ~steady;
    if (stall > 0) begin
      stall <= stall - 1;
      result_ready <= 0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall <= gap_len();
      result_ready <= 0;
    end else begin
      result_ready <= 1;
    end
  end

  task automatic send(logic [31:0] s);
    repeat (gap_len()) @(negedge clk);
    sample_valid = 1;
    sample = s;
    do @(posedge clk); while (!sample_ready);
    @(negedge clk);
    sample_valid = 0;
    sent++;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] d);
    cfg_write = 1;
    cfg_index = idx;
    cfg_data = d;
    @(negedge clk);
    cfg_write = 0;
  endtask

  function automatic logic [31:0] rand_sample();
    int k;
    k = $urandom_range(0, 19);
    if (k < 12) return {1'($urandom), 8'($urandom_range(110, 140)), 23'($urandom)};
    if (k == 12) return {1'($urandom), 31'b0};
    if (k == 13) return {1'($urandom), 8'h00, 23'($urandom)};
    if (k == 14) return {1'($urandom), 8'hFF, 23'b0};
    if (k == 15) return {1'($urandom), 8'hFF, 23'($urandom_range(1, 8388607))};
    if (k == 16) return {1'($urandom), 8'($urandom_range(200, 254)), 23'($urandom)};
    return $urandom;
  endfunction

  function automatic logic [31:0] rand_eps();
    case ($urandom_range(0, 7))
      0: return ZeroBits;
      1: return 32'hFFFF_FFFF;
      2: return 32'hBF80_0000;
      3: return OneBits;
      4: return $urandom;
      default: return EpsReset;
    endcase
  endfunction

  initial begin
    int len;
    repeat (8) @(negedge clk);
    rst = 0;
    @(negedge clk);

    // directed rows
    write_reg(REG_ROW_LENGTH, 7'd4);
    send(32'h0000_0000); send(32'h8000_0000); send(32'h7F7F_FFFF); send(32'h0000_0001);
    send(32'h0080_0000); send(32'hFF80_0000); send(32'h7FC0_0001); send(32'h3F80_0000);
    drain();
    write_reg(REG_ROW_LENGTH, 7'd0);
    write_reg(REG_EPS, ZeroBits);
    send(32'h0000_0000);
    send(32'h8000_0000);
    drain();
    write_reg(REG_ROW_LENGTH, 7'd127);
    write_reg(REG_EPS, 32'hBF80_0000);
    for (int i = 0; i < 64; i++) send(rand_sample());
    drain();
    write_reg(REG_ROW_LENGTH, 7'd8);
    write_reg(REG_EPS, 32'hFFFF_FFFF);
    send(32'h4000_0000); send(32'hC040_0000); send(32'h007F_FFFF);
    drain();
    write_reg(REG_ROW_LENGTH, 7'd2);
    write_reg(REG_EPS, EpsReset);
    send(32'h3F00_0000);
    drain();

    // random phases
    while (sent < 240) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 8);
      write_reg(REG_ROW_LENGTH, 7'(len));
      if ($urandom_range(0, 1)) write_reg(REG_EPS, rand_eps());
      if (len == 0) len = 1;
      if (len > MaxRow) len = MaxRow;
      repeat ($urandom_range(1, 3) * len) if (sent < 260) send(rand_sample());
      drain();
    end

    drain();
    if (errors == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
